/* src/ffba_pkg.sv */
// shared types, codes and constants for the first-fit block allocator
package ffba_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int UNIT_W = 33;

    localparam logic [31:0] RESET_HEAP_BASE = 32'h0020_0000;
    localparam logic [24:0] RESET_HEAP_BYTES = 25'h001_0000;
    localparam logic [UNIT_W-1:0] ADDR_SPACE_END = 33'h1_0000_0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd1;

    typedef enum logic [1:0] {
        ACT_ALLOC     = 2'd0,
        ACT_FREE_ID   = 2'd1,
        ACT_FREE_LAST = 2'd2,
        ACT_CLEAR     = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        STS_NEW          = 4'd0,
        STS_REUSED       = 4'd1,
        STS_FREED        = 4'd2,
        STS_ALREADY_FREE = 4'd3,
        STS_NOT_FOUND    = 4'd4,
        STS_NONE_USED    = 4'd5,
        STS_BAD          = 4'd6,
        STS_HEAP_FULL    = 4'd7,
        STS_TABLE_FULL   = 4'd8,
        STS_CLEARED      = 4'd9
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_UP,
        S_SCAN_DN,
        S_READ,
        S_LOAD,
        S_END,
        S_TOP,
        S_UPD_ACTIVE,
        S_UPD_FREE,
        S_RESERVED,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [23:0] request_size;
        logic [5:0]  block_id;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] block_address;
        logic [5:0]  granted_id;
        logic [23:0] entry_size;
        logic [24:0] live_bytes;
        logic [24:0] reusable_bytes;
        logic [24:0] reserved_bytes;
        logic [5:0]  entries_in_use;
    } t_rsp;

    typedef struct packed {
        logic [31:0] addr;
        logic [23:0] size;
    } t_entry;

endpackage

/* src/first_fit_block_allocator.sv */
// first-fit heap block allocator: entry table, bump pointer and sequencer
//
// Requests enter on i_in_valid/o_in_ready as t_req items (allocate, free by
// id, free latest, clear); each yields exactly one t_rsp item on
// o_out_valid/i_out_ready with a status, the entry concerned and the
// running byte and entry statistics after the request.
// The user is to write the heap registers through i_cfg_we/i_cfg_index/
// i_cfg_data only while the block is idle; the block does not enforce this,
// and a write does not move the bump pointer. One request at a time goes
// through a sequencer around a single 33-bit add/subtract unit: decode, a
// table scan, an entry read, heap checks for a new entry, the byte count
// updates and the reserved-byte and final steps; clear and a bad, unknown or
// already free request go from decode to the reserved-byte step. o_in_ready
// is high only while idle, so the next item can be taken in the cycle after
// the result is registered. The result sits in an output register; a new
// item may be accepted while it waits, and the next result then holds in the
// final step until the receiver takes the pending one.
// Reset (synchronous, active low) empties the table, restores the heap
// registers and sets the bump pointer to the heap base; no clearing pass.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_state r_state, n_state;

    logic [31:0]       r_heap_base;
    logic [24:0]       r_heap_bytes;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_bump;
    logic [24:0]       r_active;
    logic [24:0]       r_free;

    t_req              r_req;
    t_status           r_status;
    logic [CNT_W-1:0]  r_idx;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pidx;
    logic [IDX_W-1:0]  r_tgt;
    logic [31:0]       r_res_addr;
    logic [23:0]       r_res_size;
    logic [5:0]        r_res_id;
    logic [UNIT_W-1:0] r_end;
    logic [24:0]       r_resv;

    logic              r_out_valid;
    t_rsp              r_out;

    logic [MAX_ENTRIES-1:0] r_used;
    t_entry            mem [MAX_ENTRIES];
    t_entry            r_rd_data;

    // control from the sequencer
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [UNIT_W-1:0] u_a, u_b, u_sum;
    logic              u_sub;

    // decode and scan conditions
    logic              accept;
    logic              scan_issue;
    logic              scan_hit;
    logic              scan_done;
    logic [5:0]        id_m1;
    logic              id_bad, id_missing, id_free;
    logic [IDX_W-1:0]  dn_idx;
    logic              heap_full, table_full;
    logic              out_free;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free   = !r_out_valid || i_out_ready;

    // shared add/subtract unit
    assign u_sum = u_a + (u_sub ? ~u_b : u_b) + {{(UNIT_W-1){1'b0}}, u_sub};

    assign scan_issue = (r_idx < r_count);
    // size >= request when the subtraction leaves no borrow
    assign scan_hit   = r_pend && !r_used[r_pidx] && !u_sum[UNIT_W-1];
    assign scan_done  = !r_pend && !scan_issue;

    assign id_m1      = r_req.block_id - 6'd1;
    assign id_bad     = (r_req.block_id == 6'd0);
    assign id_missing = (r_req.block_id > 6'(r_count));
    assign id_free    = !r_used[id_m1[IDX_W-1:0]];
    assign dn_idx     = IDX_W'(r_idx - CNT_W'(1));

    assign heap_full  = (u_sum >= r_end);
    assign table_full = (r_count >= CNT_W'(MAX_ENTRIES));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_req.action)
                    ACT_ALLOC: begin
                        n_state = (r_req.request_size == 24'd0) ? S_RESERVED : S_SCAN_UP;
                    end
                    ACT_FREE_ID: begin
                        n_state = (id_bad || id_missing || id_free) ? S_RESERVED : S_READ;
                    end
                    ACT_FREE_LAST: n_state = S_SCAN_DN;
                    default:       n_state = S_RESERVED;
                endcase
            end
            S_SCAN_UP: begin
                if (scan_hit) n_state = S_UPD_ACTIVE;
                else if (scan_done) n_state = S_END;
            end
            S_SCAN_DN: begin
                if (r_idx == '0) n_state = S_RESERVED;
                else if (r_used[dn_idx]) n_state = S_READ;
            end
            S_READ:       n_state = S_LOAD;
            S_LOAD:       n_state = S_UPD_ACTIVE;
            S_END:        n_state = S_TOP;
            S_TOP: begin
                n_state = (heap_full || table_full) ? S_RESERVED : S_UPD_ACTIVE;
            end
            S_UPD_ACTIVE: n_state = (r_status == STS_NEW) ? S_RESERVED : S_UPD_FREE;
            S_UPD_FREE:   n_state = S_RESERVED;
            S_RESERVED:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: unit operands and memory port control
    always_comb begin
        u_a     = '0;
        u_b     = '0;
        u_sub   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx[IDX_W-1:0];
        mem_we  = 1'b0;
        case (r_state)
            S_SCAN_UP: begin
                u_a   = UNIT_W'(r_rd_data.size);
                u_b   = UNIT_W'(r_req.request_size);
                u_sub = 1'b1;
                rd_en = scan_issue && !scan_hit;
            end
            S_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_tgt;
            end
            S_END: begin
                u_a = UNIT_W'(r_heap_base);
                u_b = UNIT_W'(r_heap_bytes);
            end
            S_TOP: begin
                u_a    = UNIT_W'(r_bump);
                u_b    = UNIT_W'(r_req.request_size);
                mem_we = !heap_full && !table_full;
            end
            S_UPD_ACTIVE: begin
                u_a   = UNIT_W'(r_active);
                u_b   = UNIT_W'(r_res_size);
                u_sub = (r_status == STS_FREED);
            end
            S_UPD_FREE: begin
                u_a   = UNIT_W'(r_free);
                u_b   = UNIT_W'(r_res_size);
                u_sub = (r_status != STS_FREED);
            end
            S_RESERVED: begin
                u_a   = UNIT_W'(r_bump);
                u_b   = UNIT_W'(r_heap_base);
                u_sub = 1'b1;
            end
            default: begin
                u_sub = 1'b0;
            end
        endcase
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= '{addr: r_bump, size: r_req.request_size};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // used marks: valid only below the entry count, so no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD_ACTIVE) begin
            r_used[r_tgt] <= (r_status != STS_FREED);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_base  <= RESET_HEAP_BASE;
            r_heap_bytes <= RESET_HEAP_BYTES;
            r_count      <= '0;
            r_bump       <= RESET_HEAP_BASE;
            r_active     <= '0;
            r_free       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                    REG_HEAP_BYTES: r_heap_bytes <= i_cfg_data[24:0];
                    default:        r_heap_base  <= r_heap_base;
                endcase
            end
            case (r_state)
                S_DECODE: begin
                    if (r_req.action == ACT_CLEAR) begin
                        r_count  <= '0;
                        r_bump   <= r_heap_base;
                        r_active <= '0;
                        r_free   <= '0;
                    end
                end
                S_TOP: begin
                    if (!heap_full && !table_full) begin
                        r_bump  <= u_sum[31:0];
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                S_UPD_ACTIVE: r_active <= u_sum[24:0];
                S_UPD_FREE:   r_free   <= u_sum[24:0];
                default:      r_count  <= r_count;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_item;
        end
        case (r_state)
            S_DECODE: begin
                r_res_addr <= '0;
                r_res_size <= '0;
                r_res_id   <= '0;
                // free latest scans down from the top of the table
                r_idx      <= (r_req.action == ACT_FREE_LAST) ? r_count : '0;
                r_pend     <= 1'b0;
                case (r_req.action)
                    ACT_ALLOC: begin
                        r_status <= (r_req.request_size == 24'd0) ? STS_BAD : STS_NEW;
                    end
                    ACT_FREE_ID: begin
                        r_tgt <= id_m1[IDX_W-1:0];
                        if (id_bad) r_status <= STS_BAD;
                        else if (id_missing) r_status <= STS_NOT_FOUND;
                        else if (id_free) r_status <= STS_ALREADY_FREE;
                        else r_status <= STS_FREED;
                    end
                    ACT_FREE_LAST: begin
                        r_status <= STS_FREED;
                    end
                    default: r_status <= STS_CLEARED;
                endcase
            end
            S_SCAN_UP: begin
                r_pend <= scan_issue && !scan_hit;
                r_pidx <= r_idx[IDX_W-1:0];
                if (scan_issue && !scan_hit) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (scan_hit) begin
                    r_tgt      <= r_pidx;
                    r_status   <= STS_REUSED;
                    r_res_addr <= r_rd_data.addr;
                    r_res_size <= r_rd_data.size;
                    r_res_id   <= 6'(r_pidx) + 6'd1;
                end
            end
            S_SCAN_DN: begin
                if (r_idx == '0) begin
                    r_status <= STS_NONE_USED;
                end else if (r_used[dn_idx]) begin
                    r_tgt <= dn_idx;
                end else begin
                    r_idx <= r_idx - CNT_W'(1);
                end
            end
            S_LOAD: begin
                r_res_addr <= r_rd_data.addr;
                r_res_size <= r_rd_data.size;
                r_res_id   <= 6'(r_tgt) + 6'd1;
            end
            S_END: begin
                // heap end capped at the top of the address space
                r_end <= u_sum[UNIT_W-1] ? ADDR_SPACE_END : u_sum;
            end
            S_TOP: begin
                if (heap_full) begin
                    r_status <= STS_HEAP_FULL;
                end else if (table_full) begin
                    r_status <= STS_TABLE_FULL;
                end else begin
                    r_tgt      <= r_count[IDX_W-1:0];
                    r_res_addr <= r_bump;
                    r_res_size <= r_req.request_size;
                    r_res_id   <= 6'(r_count) + 6'd1;
                end
            end
            S_RESERVED: r_resv <= u_sum[24:0];
            S_DONE: begin
                if (out_free) begin
                    r_out.status         <= r_status;
                    r_out.block_address  <= r_res_addr;
                    r_out.granted_id     <= r_res_id;
                    r_out.entry_size     <= r_res_size;
                    r_out.live_bytes     <= r_active;
                    r_out.reusable_bytes <= r_free;
                    r_out.reserved_bytes <= r_resv;
                    r_out.entries_in_use <= 6'(r_count);
                end
            end
            default: r_pend <= r_pend;
        endcase
    end

    // the table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    // a new block is always the last entry of the table
    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_NEW) |->
        (r_out.granted_id == r_out.entries_in_use && r_out.granted_id != 6'd0))
        else $error("new block id does not match entry count");

    // clear leaves all statistics at zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_CLEARED) |->
        (r_out.live_bytes == '0 && r_out.reusable_bytes == '0 &&
         r_out.reserved_bytes == '0 && r_out.entries_in_use == '0))
        else $error("statistics not zero after clear");

    // failures and clear report no entry
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != STS_NEW && r_out.status != STS_REUSED &&
         r_out.status != STS_FREED) |->
        (r_out.granted_id == '0 && r_out.block_address == '0 && r_out.entry_size == '0))
        else $error("failing result carries an entry");

    // an accepted item starts the sequencer in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE && !o_in_ready))
        else $error("accepted item not decoded");

endmodule
